@@ design/cwa_pkg.sv @@
// Shared types and constants for the coil weight apply block.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwa_pkg;

	// Field widths fixed by the item formats.
	localparam int CIDX_W    = 4;
	localparam int SMP_W     = 16;
	localparam int OUT_W     = 24;
	localparam int CFG_W     = 5;
	localparam int MAX_COILS = 16;

	// Arithmetic widths: 16x16 products, complex term, 16-term sum.
	localparam int PROD_W = 2 * SMP_W;
	localparam int TERM_W = PROD_W + 1;
	localparam int ACC_W  = TERM_W + 4;
	localparam int QBITS  = 14;
	localparam int DIFF_W = OUT_W + 1;

	// Item opcodes.
	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Reset value of the active coil count.
	localparam logic [CFG_W-1:0] COILS_RESET = 5'd16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;      // an input beat is accepted this cycle
		logic              issue;     // one multiply-accumulate step enters the pipe
		logic              first;     // step starts a new row sum
		logic              last;      // step ends the row sum
		logic [CIDX_W-1:0] col;       // source coil of this step
		logic [CIDX_W-1:0] row;       // target coil of the current row
		logic              row_last;  // current row is the last active coil
	} cwa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic row_done;  // a row result is loaded into the output register
		logic out_busy;  // output register holds a beat that is not taken
	} cwa_sts_t;

	// Tag carried along the multiply-accumulate pipe.
	typedef struct packed {
		logic              vld;
		logic              first;
		logic              last;
		logic [CIDX_W-1:0] row;
		logic              row_last;
	} cwa_tag_t;

endpackage

`default_nettype wire

@@ design/cwa_item_if.sv @@
// Input channel of the coil weight apply block: weight and sample beats.
// Depends on cwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cwa_item_if import cwa_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [CIDX_W-1:0]        src_coil;
	logic [CIDX_W-1:0]        dst_coil;
	logic signed [SMP_W-1:0]  val_re;
	logic signed [SMP_W-1:0]  val_im;
	logic                     vec_last;

	modport source (
		output valid, opcode, src_coil, dst_coil, val_re, val_im, vec_last,
		input  ready
	);

	modport sink (
		input  valid, opcode, src_coil, dst_coil, val_re, val_im, vec_last,
		output ready
	);

endinterface

`default_nettype wire

@@ design/cwa_result_if.sv @@
// Output channel of the coil weight apply block: one beat per target coil.
// Depends on cwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cwa_result_if import cwa_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  out_re;
	logic signed [OUT_W-1:0]  out_im;
	logic [CIDX_W-1:0]        out_coil;
	logic                     out_last;

	modport source (
		output valid, out_re, out_im, out_coil, out_last,
		input  ready
	);

	modport sink (
		input  valid, out_re, out_im, out_coil, out_last,
		output ready
	);

endinterface

`default_nettype wire

@@ design/cwa_ctrl.sv @@
// Controller of the coil weight apply block: input handshake, row and column
// sequencing of the multiply-accumulate pipe. Depends on cwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwa_ctrl import cwa_pkg::*; #(
	parameter int NUM_COILS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_opcode,
	input  logic             item_last,
	output logic             item_ready,
	input  logic [CFG_W-1:0] active_coils,
	output cwa_cmd_t         cmd,
	input  cwa_sts_t         sts
);

	localparam int LIM = (NUM_COILS < MAX_COILS) ? NUM_COILS : MAX_COILS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WAIT  = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]        state_q;
	logic [CIDX_W-1:0] s_q;
	logic [CIDX_W-1:0] r_q;
	logic [CFG_W-1:0]  n;
	logic [CFG_W-1:0]  n_m1;
	logic              s_last;
	logic              r_last;
	logic              accept;
	logic              start;

	// Effective coil count, clamped to the supported range.
	always_comb begin
		priority if (active_coils == '0) begin
			n = CFG_W'(1);
		end else if (int'(active_coils) > LIM) begin
			n = CFG_W'(LIM);
		end else begin
			n = active_coils;
		end
	end

	assign n_m1   = n - CFG_W'(1);
	assign s_last = (CFG_W'(s_q) == n_m1);
	assign r_last = (CFG_W'(r_q) == n_m1);

	// Input beats are taken only while no vector is being processed.
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign start      = accept && (item_opcode == OP_SAMPLE) && item_last;

	// Commands to the datapath.
	always_comb begin
		cmd.load     = accept;
		cmd.issue    = (state_q == ST_ISSUE);
		cmd.first    = (s_q == '0);
		cmd.last     = s_last;
		cmd.col      = s_q;
		cmd.row      = r_q;
		cmd.row_last = r_last;
	end

	// Sequencer: one row per target coil, one step per source coil.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			s_q     <= '0;
			r_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						r_q     <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// A row starts only when its result will find the output free.
					if (!sts.out_busy) begin
						s_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					s_q <= s_q + CIDX_W'(1);
					if (s_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sts.row_done) begin
						if (r_last) begin
							state_q <= ST_IDLE;
						end else begin
							r_q     <= r_q + CIDX_W'(1);
							state_q <= ST_WAIT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A row result arrives only after all of its steps were issued.
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sts.row_done |-> (state_q == ST_DRAIN))
		else $error("row result outside drain");

	// Steps never address a coil beyond the active count.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (CFG_W'(cmd.col) < n))
		else $error("step beyond active coils");

	// A row result never overwrites an untaken output beat.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sts.row_done |-> !sts.out_busy)
		else $error("output register overwritten");

	// After the last row the block is ready for input again.
	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) && sts.row_done && r_last |=> item_ready)
		else $error("no return to idle after last row");
`endif

endmodule

`default_nettype wire

@@ design/cwa_dp.sv @@
// Datapath of the coil weight apply block: weight and sample stores, complex
// multiply-accumulate pipe, rounding, subtraction, saturation, output register.
// Depends on cwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwa_dp import cwa_pkg::*; #(
	parameter int NUM_COILS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cwa_cmd_t                cmd,
	output cwa_sts_t                sts,
	input  logic                    opcode,
	input  logic [CIDX_W-1:0]       src_coil,
	input  logic [CIDX_W-1:0]       dst_coil,
	input  logic signed [SMP_W-1:0] val_re,
	input  logic signed [SMP_W-1:0] val_im,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_re,
	output logic signed [OUT_W-1:0] out_im,
	output logic [CIDX_W-1:0]       out_coil,
	output logic                    out_last
);

	localparam int CW     = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
	localparam int WDEPTH = 1 << (2 * CW);
	localparam int SDEPTH = 1 << CW;

	localparam logic signed [DIFF_W-1:0] SAT_MAX = DIFF_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [DIFF_W-1:0] SAT_MIN = -DIFF_W'(1 << (OUT_W - 1));
	localparam logic signed [ACC_W-1:0]  RND     = ACC_W'(1 << (QBITS - 1));

	// Stores.
	logic signed [SMP_W-1:0] wmem_re [WDEPTH];
	logic signed [SMP_W-1:0] wmem_im [WDEPTH];
	logic signed [SMP_W-1:0] smem_re [SDEPTH];
	logic signed [SMP_W-1:0] smem_im [SDEPTH];

	logic              src_ok;
	logic              dst_ok;
	logic [2*CW-1:0]   wr_addr;
	logic [2*CW-1:0]   rd_addr;

	// Pipe registers.
	cwa_tag_t                 tag_s1;
	cwa_tag_t                 tag_s2;
	logic signed [SMP_W-1:0]  w_re_s1, w_im_s1, k_re_s1, k_im_s1;
	logic signed [PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
	logic                     done_s3;
	logic [CIDX_W-1:0]        row_s3;
	logic                     row_last_s3;
	logic signed [SMP_W-1:0]  krow_re_q, krow_im_q;

	logic signed [TERM_W-1:0] term_re, term_im;
	logic signed [ACC_W-1:0]  rnd_re, rnd_im;
	logic signed [ACC_W-QBITS-1:0] q_re, q_im;
	logic signed [DIFF_W-1:0] diff_re, diff_im;
	logic signed [OUT_W-1:0]  sat_re, sat_im;

	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_re_q, out_im_q;
	logic [CIDX_W-1:0]        out_coil_q;
	logic                     out_last_q;

	// Indexes outside the stores are dropped.
	assign src_ok  = int'(src_coil) < NUM_COILS;
	assign dst_ok  = int'(dst_coil) < NUM_COILS;
	assign wr_addr = {CW'(src_coil), CW'(dst_coil)};
	assign rd_addr = {CW'(cmd.col), CW'(cmd.row)};

	// Store writes from accepted beats.
	always_ff @(posedge clk) begin
		if (cmd.load && (opcode == OP_WEIGHT) && src_ok && dst_ok) begin
			wmem_re[wr_addr] <= val_re;
			wmem_im[wr_addr] <= val_im;
		end
		if (cmd.load && (opcode == OP_SAMPLE) && src_ok) begin
			smem_re[CW'(src_coil)] <= val_re;
			smem_im[CW'(src_coil)] <= val_im;
		end
	end

	// Registered store reads: one weight and one sample per step, plus the
	// sample of the current row for the final subtraction.
	always_ff @(posedge clk) begin
		w_re_s1   <= wmem_re[rd_addr];
		w_im_s1   <= wmem_im[rd_addr];
		k_re_s1   <= smem_re[CW'(cmd.col)];
		k_im_s1   <= smem_im[CW'(cmd.col)];
		krow_re_q <= smem_re[CW'(cmd.row)];
		krow_im_q <= smem_im[CW'(cmd.row)];
	end

	// Complex product, four real multipliers.
	always_ff @(posedge clk) begin
		p_rr_s2 <= k_re_s1 * w_re_s1;
		p_ii_s2 <= k_im_s1 * w_im_s1;
		p_ri_s2 <= k_re_s1 * w_im_s1;
		p_ir_s2 <= k_im_s1 * w_re_s1;
	end

	// Pipe tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			done_s3     <= 1'b0;
			row_s3      <= '0;
			row_last_s3 <= 1'b0;
		end else begin
			tag_s1.vld      <= cmd.issue;
			tag_s1.first    <= cmd.first;
			tag_s1.last     <= cmd.last;
			tag_s1.row      <= cmd.row;
			tag_s1.row_last <= cmd.row_last;
			tag_s2          <= tag_s1;
			done_s3         <= tag_s2.vld && tag_s2.last;
			row_s3          <= tag_s2.row;
			row_last_s3     <= tag_s2.row_last;
		end
	end

	// Accumulation of the row sum.
	assign term_re = TERM_W'(p_rr_s2) - TERM_W'(p_ii_s2);
	assign term_im = TERM_W'(p_ri_s2) + TERM_W'(p_ir_s2);

	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			if (tag_s2.first) begin
				acc_re_q <= ACC_W'(term_re);
				acc_im_q <= ACC_W'(term_im);
			end else begin
				acc_re_q <= acc_re_q + ACC_W'(term_re);
				acc_im_q <= acc_im_q + ACC_W'(term_im);
			end
		end
	end

	// Round half up, drop the fraction, subtract the row sample, saturate.
	assign rnd_re  = acc_re_q + RND;
	assign rnd_im  = acc_im_q + RND;
	assign q_re    = rnd_re[ACC_W-1:QBITS];
	assign q_im    = rnd_im[ACC_W-1:QBITS];
	assign diff_re = DIFF_W'(q_re) - DIFF_W'(krow_re_q);
	assign diff_im = DIFF_W'(q_im) - DIFF_W'(krow_im_q);

	always_comb begin
		priority if (diff_re > SAT_MAX) begin
			sat_re = OUT_W'(SAT_MAX);
		end else if (diff_re < SAT_MIN) begin
			sat_re = OUT_W'(SAT_MIN);
		end else begin
			sat_re = OUT_W'(diff_re);
		end
		priority if (diff_im > SAT_MAX) begin
			sat_im = OUT_W'(SAT_MAX);
		end else if (diff_im < SAT_MIN) begin
			sat_im = OUT_W'(SAT_MIN);
		end else begin
			sat_im = OUT_W'(diff_im);
		end
	end

	// Output register: loaded once per row, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			out_re_q   <= sat_re;
			out_im_q   <= sat_im;
			out_coil_q <= row_s3;
			out_last_q <= row_last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign out_coil  = out_coil_q;
	assign out_last  = out_last_q;

	always_comb begin
		sts.row_done = done_s3;
		sts.out_busy = out_valid_q && !out_ready;
	end

endmodule

`default_nettype wire

@@ design/coil_weight_apply_minus_input.sv @@
// Top level of the coil weight apply block: configuration register, APB port,
// controller and datapath. Depends on cwa_pkg, cwa_item_if, cwa_result_if,
// cwa_ctrl and cwa_dp.
//
//   Channel   Direction  Content
//   items     in         weight entry or coil sample, one per beat
//   results   out        mixed value minus input for one target coil
//   APB       in/out     active_coils at byte address 0
//
// Weight beats and samples without vec_last only write the stores; input beats
// are taken only while no vector is in progress. A sample with vec_last starts
// n rows (n = active coil count); each row waits for a free output register,
// then issues n steps, one per source coil, through the read, multiply and
// accumulate stages of the single complex multiply-accumulate unit.
// A row starts only when the output register is free, so output stalls delay
// the next row. Reset clears control state and sets active_coils to 16;
// weight and sample stores hold no defined value until written.
`timescale 1ns / 1ps
`default_nettype none

module coil_weight_apply_minus_input import cwa_pkg::*; #(
	parameter int NUM_COILS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	cwa_item_if.sink     items,
	cwa_result_if.source results,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [CFG_W-1:0] active_coils_q;
	logic             cfg_sel;
	cwa_cmd_t         cmd;
	cwa_sts_t         sts;

	// Register decode: only word 0 is implemented.
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_coils_q <= COILS_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			active_coils_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = cfg_sel ? 32'(active_coils_q) : 32'd0;

	// Sequencer.
	cwa_ctrl #(
		.NUM_COILS (NUM_COILS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (items.valid),
		.item_opcode  (items.opcode),
		.item_last    (items.vec_last),
		.item_ready   (items.ready),
		.active_coils (active_coils_q),
		.cmd          (cmd),
		.sts          (sts)
	);

	// Stores and arithmetic.
	cwa_dp #(
		.NUM_COILS (NUM_COILS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (items.opcode),
		.src_coil  (items.src_coil),
		.dst_coil  (items.dst_coil),
		.val_re    (items.val_re),
		.val_im    (items.val_im),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_re    (results.out_re),
		.out_im    (results.out_im),
		.out_coil  (results.out_coil),
		.out_last  (results.out_last)
	);

endmodule

`default_nettype wire
